// File: design/assert_macros.svh
// Assertion macros used by the frame allocator datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clock, resetn, expr) \
    name: assert property (@(posedge clock) disable iff (!resetn) (expr)) \
        else $error("assertion failed");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(name, clock, resetn, expr)
`define ASSERT_IMPLIES(name, clock, resetn, ante, cons)

`endif

`endif

// File: design/fa_lru_pkg.sv
// Types, constants and command words of the aging LRU frame allocator.
`timescale 1ns / 1ps

package fa_lru_pkg;

    localparam int FRAMES       = 64;
    localparam int FRAME_W      = $clog2(FRAMES);
    localparam int COUNT_W      = $clog2(FRAMES + 1);
    localparam int COUNTER_BITS = 16;
    localparam int FRAME_SHIFT  = 10;
    localparam int ADDR_W       = 32;
    localparam int PAGE_W       = ADDR_W - FRAME_SHIFT;
    localparam int OWNER_W      = 8;
    localparam int MODE_W       = 2;

    localparam logic [OWNER_W-1:0]      NO_OWNER    = '1;
    localparam logic [COUNTER_BITS-1:0] COUNTER_TOP = {1'b1, {(COUNTER_BITS-1){1'b0}}};

    localparam logic [MODE_W-1:0] MODE_TOUCH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MARK    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd3;

    // Operation carried out on each frame during a sweep.
    localparam logic [1:0] OP_NONE    = 2'd0;
    localparam logic [1:0] OP_TOUCH   = 2'd1;
    localparam logic [1:0] OP_SCAN    = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FRAME_W-1:0] frame;
        logic [OWNER_W-1:0] owner;
        logic               kind;
        logic [ADDR_W-1:0]  phys_address;
    } item_t;

    typedef struct packed {
        logic [FRAME_W-1:0] result_frame;
        logic               evicted;
        logic [OWNER_W-1:0] victim_owner;
        logic               victim_writeback;
        logic [COUNT_W-1:0] freed_count;
        logic [COUNT_W-1:0] writeback_count;
        logic               status;
    } res_t;

    typedef struct packed {
        logic       load;
        logic       idx_one;
        logic       sweep;
        logic [1:0] op;
        logic       take_free;
        logic       sel_best;
        logic       take_victim;
        logic       mark;
        logic       res_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              queue_empty;
        logic              idx_last;
        logic              out_free;
    } dp_stat_t;

endpackage

// File: design/fa_lru_if.sv
// Request and response channel interfaces of the frame allocator.
`timescale 1ns / 1ps

interface fa_lru_req_if import fa_lru_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [FRAME_W-1:0] frame;
    logic [OWNER_W-1:0] owner;
    logic               kind;
    logic [ADDR_W-1:0]  phys_address;

    modport source (output valid, mode, frame, owner, kind, phys_address, input ready);
    modport sink (input valid, mode, frame, owner, kind, phys_address, output ready);
endinterface

interface fa_lru_rsp_if import fa_lru_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] result_frame;
    logic               evicted;
    logic [OWNER_W-1:0] victim_owner;
    logic               victim_writeback;
    logic [COUNT_W-1:0] freed_count;
    logic [COUNT_W-1:0] writeback_count;
    logic               status;

    modport source (output valid, result_frame, evicted, victim_owner, victim_writeback,
                    freed_count, writeback_count, status, input ready);
    modport sink (input valid, result_frame, evicted, victim_owner, victim_writeback,
                  freed_count, writeback_count, status, output ready);
endinterface

// File: design/fa_lru_dp.sv
// Datapath of the frame allocator: frame tables, free queue, sweep stage, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fa_lru_dp import fa_lru_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  item_t    item,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat,
    output res_t     res,
    output logic     res_valid,
    input  logic     res_ready
);

    localparam int SUM_W = FRAME_W + 1;

    // Captured request word.
    logic [MODE_W-1:0]  mode_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [ADDR_W-1:0]  addr_reg;

    // Sweep index and the processing stage, which holds the index of the previous cycle.
    logic [FRAME_W-1:0] idx_reg;
    logic               proc_reg;
    logic [1:0]         proc_op_reg;
    logic [FRAME_W-1:0] proc_idx_reg;

    logic [FRAME_W-1:0] target_reg;
    logic               tgt_en_reg;
    logic               tgt_clr_reg;

    // Memories with registered read data.
    logic [COUNTER_BITS-1:0] age_mem [FRAMES];
    logic [COUNTER_BITS-1:0] age_rd_reg;
    logic [OWNER_W-1:0]      owner_mem [FRAMES];
    logic [OWNER_W-1:0]      owner_rd_reg;
    logic [FRAME_W-1:0]      q_mem [FRAMES];
    logic [FRAME_W-1:0]      q_rd_reg;
    logic                    q_hit_reg;

    logic [FRAMES-1:0] q_written_reg, q_written_next;
    logic [FRAMES-1:0] valid_reg, valid_next;
    logic [FRAMES-1:0] dirty_reg, dirty_next;
    logic [FRAME_W-1:0] head_reg, head_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic [FRAME_W-1:0]      best_reg;
    logic [COUNTER_BITS-1:0] min_reg;

    logic [FRAME_W-1:0] fsel_reg;
    logic               evict_reg;
    logic [OWNER_W-1:0] vown_reg;
    logic               vwb_reg;
    logic [COUNT_W-1:0] freed_reg;
    logic [COUNT_W-1:0] wbc_reg;

    res_t out_reg, out_next;
    logic out_valid_reg;

    // Combinational signals.
    logic [PAGE_W-1:0]       page;
    logic                    page_ok;
    logic [FRAME_W-1:0]      page_idx;
    logic [FRAME_W-1:0]      p;
    logic [COUNTER_BITS-1:0] shifted;
    logic [COUNTER_BITS-1:0] age_wd;
    logic                    age_we;
    logic                    rel_hit;
    logic                    push;
    logic                    scan_upd;
    logic [SUM_W-1:0]        tail_sum;
    logic [FRAME_W-1:0]      tail;
    logic [FRAME_W-1:0]      take_f;
    logic [FRAME_W-1:0]      alloc_f;
    logic                    alloc_take;
    logic                    owner_we;
    logic [FRAME_W-1:0]      owner_wa;
    logic [OWNER_W-1:0]      owner_wd;
    logic [FRAME_W-1:0]      owner_ra;

    assign page     = addr_reg[ADDR_W-1:FRAME_SHIFT];
    assign page_ok  = ADDR_W'(page) < ADDR_W'(FRAMES);
    assign page_idx = page[FRAME_W-1:0];

    assign p       = proc_idx_reg;
    assign shifted = valid_reg[p] ? (age_rd_reg >> 1) : age_rd_reg;

    // A freshly allocated frame starts from a cleared counter, so it ends the
    // sweep with only the top bit set.
    always_comb
    begin
        age_wd = shifted;
        if (tgt_en_reg && (p == target_reg))
        begin
            age_wd = tgt_clr_reg ? COUNTER_TOP : (shifted | COUNTER_TOP);
        end
    end

    assign age_we   = proc_reg && (proc_op_reg == OP_TOUCH);
    assign rel_hit  = proc_reg && (proc_op_reg == OP_RELEASE) && valid_reg[p]
                      && (owner_rd_reg == owner_reg);
    assign push     = rel_hit && (count_reg < COUNT_W'(FRAMES));
    assign scan_upd = proc_reg && (proc_op_reg == OP_SCAN)
                      && ((p == FRAME_W'(1)) || (age_rd_reg < min_reg));

    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail     = (tail_sum >= SUM_W'(FRAMES)) ? FRAME_W'(tail_sum - SUM_W'(FRAMES))
                                                   : tail_sum[FRAME_W-1:0];

    // Queue entries never written have no reset value; the head index itself is taken in their place.
    assign take_f     = q_hit_reg ? q_rd_reg : head_reg;
    assign alloc_f    = cmd.take_free ? take_f : best_reg;
    assign alloc_take = cmd.take_free || cmd.take_victim;

    assign owner_we = alloc_take || rel_hit;
    assign owner_wa = alloc_take ? alloc_f : p;
    assign owner_wd = alloc_take ? owner_reg : NO_OWNER;
    assign owner_ra = cmd.sel_best ? best_reg : idx_reg;

    always_comb
    begin
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        q_written_next = q_written_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        if (alloc_take)
        begin
            valid_next[alloc_f] = 1'b1;
            dirty_next[alloc_f] = 1'b0;
        end
        if (rel_hit)
        begin
            valid_next[p] = 1'b0;
            dirty_next[p] = 1'b0;
        end
        if (cmd.mark && page_ok)
        begin
            dirty_next[page_idx] = 1'b1;
        end
        if (push)
        begin
            q_written_next[tail] = 1'b1;
            count_next           = count_reg + COUNT_W'(1);
        end
        if (cmd.take_free)
        begin
            head_next  = (head_reg == FRAME_W'(FRAMES - 1)) ? '0 : head_reg + FRAME_W'(1);
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_comb
    begin
        out_next                  = '0;
        out_next.victim_owner     = NO_OWNER;
        case (mode_reg)
            MODE_TOUCH:
            begin
                out_next.result_frame = frame_reg;
            end
            MODE_ALLOC:
            begin
                out_next.result_frame     = fsel_reg;
                out_next.evicted          = evict_reg;
                out_next.victim_owner     = vown_reg;
                out_next.victim_writeback = vwb_reg;
            end
            MODE_MARK:
            begin
                out_next.result_frame = page_idx;
                out_next.status       = !page_ok;
            end
            MODE_RELEASE:
            begin
                out_next.freed_count     = freed_reg;
                out_next.writeback_count = wbc_reg;
            end
            default:
            begin
                out_next = out_next;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_reg      <= 1'b0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            q_written_reg <= '0;
            head_reg      <= '0;
            count_reg     <= COUNT_W'(FRAMES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            proc_reg      <= cmd.sweep;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            q_written_reg <= q_written_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        proc_op_reg  <= cmd.op;
        proc_idx_reg <= idx_reg;
        if (cmd.load)
        begin
            mode_reg    <= item.mode;
            frame_reg   <= item.frame;
            owner_reg   <= item.owner;
            addr_reg    <= item.phys_address;
            idx_reg     <= '0;
            target_reg  <= item.frame;
            tgt_en_reg  <= ADDR_W'(item.frame) < ADDR_W'(FRAMES);
            tgt_clr_reg <= 1'b0;
            evict_reg   <= 1'b0;
            vown_reg    <= NO_OWNER;
            vwb_reg     <= 1'b0;
            freed_reg   <= '0;
            wbc_reg     <= '0;
        end
        else if (cmd.idx_one)
        begin
            idx_reg <= FRAME_W'(1);
        end
        else if (alloc_take)
        begin
            idx_reg     <= '0;
            target_reg  <= alloc_f;
            tgt_en_reg  <= 1'b1;
            tgt_clr_reg <= 1'b1;
            fsel_reg    <= alloc_f;
        end
        else if (cmd.sweep)
        begin
            idx_reg <= idx_reg + FRAME_W'(1);
        end
        if (cmd.take_victim)
        begin
            evict_reg <= 1'b1;
            vown_reg  <= owner_rd_reg;
            vwb_reg   <= dirty_reg[best_reg];
        end
        if (scan_upd)
        begin
            best_reg <= p;
            min_reg  <= age_rd_reg;
        end
        if (rel_hit)
        begin
            freed_reg <= freed_reg + COUNT_W'(1);
            if (dirty_reg[p])
            begin
                wbc_reg <= wbc_reg + COUNT_W'(1);
            end
        end
        if (cmd.res_load)
        begin
            out_reg <= out_next;
        end
    end

    // Age counter memory.
    always_ff @(posedge clk)
    begin
        if (age_we)
        begin
            age_mem[p] <= age_wd;
        end
        age_rd_reg <= age_mem[idx_reg];
    end

    // Owner memory.
    always_ff @(posedge clk)
    begin
        if (owner_we)
        begin
            owner_mem[owner_wa] <= owner_wd;
        end
        owner_rd_reg <= owner_mem[owner_ra];
    end

    // Free queue memory.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[tail] <= p;
        end
        q_rd_reg  <= q_mem[head_reg];
        q_hit_reg <= q_written_reg[head_reg];
    end

    assign stat.mode        = mode_reg;
    assign stat.queue_empty = (count_reg == '0);
    assign stat.idx_last    = (idx_reg == FRAME_W'(FRAMES - 1));
    assign stat.out_free    = !out_valid_reg || res_ready;

    assign res       = out_reg;
    assign res_valid = out_valid_reg;

    `ASSERT_ALWAYS(a_count_range, clk, rst_n, count_reg <= COUNT_W'(FRAMES))
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, cmd.take_free, count_reg != '0)
    `ASSERT_IMPLIES(a_evict_when_full, clk, rst_n, cmd.take_victim, count_reg == '0)
    `ASSERT_IMPLIES(a_result_slot, clk, rst_n, cmd.res_load, !out_valid_reg || res_ready)

endmodule

// File: design/fa_lru_ctrl.sv
// Controller state machine that sequences the allocator's sweeps and result hand-off.
`timescale 1ns / 1ps

module fa_lru_ctrl import fa_lru_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DISPATCH  = 4'd1;
    localparam logic [3:0] S_POP       = 4'd2;
    localparam logic [3:0] S_TOUCH     = 4'd3;
    localparam logic [3:0] S_TOUCH_END = 4'd4;
    localparam logic [3:0] S_SCAN      = 4'd5;
    localparam logic [3:0] S_SCAN_END  = 4'd6;
    localparam logic [3:0] S_EVICT_RD  = 4'd7;
    localparam logic [3:0] S_EVICT     = 4'd8;
    localparam logic [3:0] S_RELEASE   = 4'd9;
    localparam logic [3:0] S_REL_END   = 4'd10;
    localparam logic [3:0] S_FINISH    = 4'd11;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.mode)
                    MODE_TOUCH:
                    begin
                        state_next = S_TOUCH;
                    end
                    MODE_ALLOC:
                    begin
                        // The queue head is read in this cycle for the pop.
                        if (stat.queue_empty)
                        begin
                            cmd.idx_one = 1'b1;
                            state_next  = S_SCAN;
                        end
                        else
                        begin
                            state_next = S_POP;
                        end
                    end
                    MODE_MARK:
                    begin
                        cmd.mark   = 1'b1;
                        state_next = S_FINISH;
                    end
                    MODE_RELEASE:
                    begin
                        state_next = S_RELEASE;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_POP:
            begin
                cmd.take_free = 1'b1;
                state_next    = S_TOUCH;
            end
            S_TOUCH:
            begin
                cmd.sweep = 1'b1;
                cmd.op    = OP_TOUCH;
                if (stat.idx_last)
                begin
                    state_next = S_TOUCH_END;
                end
            end
            S_TOUCH_END:
            begin
                state_next = S_FINISH;
            end
            S_SCAN:
            begin
                cmd.sweep = 1'b1;
                cmd.op    = OP_SCAN;
                if (stat.idx_last)
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                state_next = S_EVICT_RD;
            end
            S_EVICT_RD:
            begin
                cmd.sel_best = 1'b1;
                state_next   = S_EVICT;
            end
            S_EVICT:
            begin
                cmd.take_victim = 1'b1;
                state_next      = S_TOUCH;
            end
            S_RELEASE:
            begin
                cmd.sweep = 1'b1;
                cmd.op    = OP_RELEASE;
                if (stat.idx_last)
                begin
                    state_next = S_REL_END;
                end
            end
            S_REL_END:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/frame_allocator_aging_lru.sv
// Physical frame allocator with aging LRU replacement: top level.
// One request word is taken at a time and answered by one response word.
// Work is done one frame per cycle over the age and owner memories: a touch
// is a sweep over all frames, an allocate from the free queue a pop and then
// the touch sweep, an allocate that must evict a 63-frame minimum search, then
// the touch sweep, a mark dirty no sweep at all and a release owner a sweep.
// The response register lets a new request be taken while the previous
// response waits. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module frame_allocator_aging_lru import fa_lru_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    fa_lru_req_if.sink  req,
    fa_lru_rsp_if.source rsp
);

    item_t    item;
    res_t     res;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The kind bit is kept in the word but does not affect any response.
    assign item.mode         = req.mode;
    assign item.frame        = req.frame;
    assign item.owner        = req.owner;
    assign item.kind         = req.kind;
    assign item.phys_address = req.phys_address;

    fa_lru_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fa_lru_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res),
        .res_valid (rsp.valid),
        .res_ready (rsp.ready)
    );

    assign rsp.result_frame     = res.result_frame;
    assign rsp.evicted          = res.evicted;
    assign rsp.victim_owner     = res.victim_owner;
    assign rsp.victim_writeback = res.victim_writeback;
    assign rsp.freed_count      = res.freed_count;
    assign rsp.writeback_count  = res.writeback_count;
    assign rsp.status           = res.status;

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the aging LRU frame allocator: random and directed words.
`timescale 1ns / 1ps

module tb_top;
    import fa_lru_pkg::*;

    localparam int RANDOM_WORDS = 1050;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_WAIT  = 300;

    typedef struct {
        item_t word;
        bit    drain;
    } pending_t;

    logic clk;
    logic rst_n;

    fa_lru_req_if req ();
    fa_lru_rsp_if rsp ();

    frame_allocator_aging_lru dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Shadow copy of the allocator tables.
    logic                    in_use   [FRAMES];
    logic [OWNER_W-1:0]      owner_of [FRAMES];
    logic                    kind_of  [FRAMES];
    logic [COUNTER_BITS-1:0] age      [FRAMES];
    logic                    dirty    [FRAMES];
    logic [FRAME_W-1:0]      free_ring[FRAMES];
    logic [FRAME_W-1:0]      free_head;
    logic [COUNT_W-1:0]      free_cnt;

    pending_t pending_q[$];
    res_t     answer_q[$];

    int words_total;
    int words_accepted;
    int phase_len;
    int errors;
    int cycle_count;
    int evictions;
    int releases;
    int frames_freed;
    int writebacks;
    int bad_marks;

    // Every frame in use ages by one step; the named frame then gets the top bit.
    function automatic void age_all(logic [FRAME_W-1:0] hit);
        for (int i = 0; i < FRAMES; i++)
        begin
            if (in_use[i])
                age[i] = age[i] >> 1;
        end
        age[hit] = age[hit] | COUNTER_TOP;
    endfunction

    function automatic res_t apply_request(item_t w);
        res_t               r;
        logic [FRAME_W-1:0] f;
        logic [PAGE_W-1:0]  page;
        int                 best;

        r = '0;
        r.victim_owner = NO_OWNER;
        case (w.mode)
            MODE_TOUCH:
            begin
                age_all(w.frame);
                r.result_frame = w.frame;
            end
            MODE_ALLOC:
            begin
                if (free_cnt != 0)
                begin
                    f = free_ring[free_head];
                    free_head = free_head + 1'b1;
                    free_cnt = free_cnt - 1'b1;
                end
                else
                begin
                    // Frame 0 is never a victim; ties keep the lowest index.
                    best = 1;
                    for (int i = 2; i < FRAMES; i++)
                    begin
                        if (age[i] < age[best])
                            best = i;
                    end
                    f = FRAME_W'(best);
                    r.evicted = 1'b1;
                    r.victim_owner = owner_of[f];
                    r.victim_writeback = dirty[f];
                end
                in_use[f] = 1'b1;
                owner_of[f] = w.owner;
                kind_of[f] = w.kind;
                age[f] = '0;
                dirty[f] = 1'b0;
                age_all(f);
                r.result_frame = f;
            end
            MODE_MARK:
            begin
                page = w.phys_address[ADDR_W-1:FRAME_SHIFT];
                r.result_frame = page[FRAME_W-1:0];
                if (page >= FRAMES)
                    r.status = 1'b1;
                else
                    dirty[page[FRAME_W-1:0]] = 1'b1;
            end
            default:
            begin
                for (int i = 0; i < FRAMES; i++)
                begin
                    if (in_use[i] && owner_of[i] == w.owner)
                    begin
                        if (dirty[i])
                            r.writeback_count = r.writeback_count + 1'b1;
                        dirty[i] = 1'b0;
                        in_use[i] = 1'b0;
                        owner_of[i] = NO_OWNER;
                        if (free_cnt < FRAMES)
                        begin
                            free_ring[free_head + free_cnt[FRAME_W-1:0]] = FRAME_W'(i);
                            free_cnt = free_cnt + 1'b1;
                        end
                        r.freed_count = r.freed_count + 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic void add_word(logic [MODE_W-1:0] mode, logic [FRAME_W-1:0] frame,
                                     logic [OWNER_W-1:0] owner, logic kind,
                                     logic [ADDR_W-1:0] addr, bit drain);
        pending_t p;

        p.word.mode = mode;
        p.word.frame = frame;
        p.word.owner = owner;
        p.word.kind = kind;
        p.word.phys_address = addr;
        p.drain = drain;
        pending_q.push_back(p);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic int idle_phase();
        if (words_accepted < phase_len)
            return 0;
        else if (words_accepted < 2 * phase_len)
            return 1;
        return 2;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            in_use[i] = 1'b0;
            owner_of[i] = NO_OWNER;
            kind_of[i] = 1'b0;
            age[i] = '0;
            dirty[i] = 1'b0;
            free_ring[i] = FRAME_W'(i);
        end
        free_head = '0;
        free_cnt = COUNT_W'(FRAMES);
    end

    // Driver: presents pending words and predicts each one as it is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        pending_t p;
        item_t    w;
        res_t     r;
        int       gap_pct;

        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.mode <= MODE_TOUCH;
            req.frame <= '0;
            req.owner <= '0;
            req.kind <= 1'b0;
            req.phys_address <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                w.mode = req.mode;
                w.frame = req.frame;
                w.owner = req.owner;
                w.kind = req.kind;
                w.phys_address = req.phys_address;
                r = apply_request(w);
                answer_q.push_back(r);
                words_accepted++;
                evictions += r.evicted;
                bad_marks += r.status;
                if (w.mode == MODE_RELEASE)
                begin
                    releases++;
                    frames_freed += r.freed_count;
                    writebacks += r.writeback_count;
                end
            end
            if (!req.valid || req.ready)
            begin
                gap_pct = (idle_phase() == 0) ? 15 : (idle_phase() == 1) ? 71 : 0;
                if (pending_q.size() == 0 || (pending_q[0].drain && answer_q.size() != 0)
                    || $urandom_range(99) < gap_pct)
                begin
                    req.valid <= 1'b0;
                end
                else
                begin
                    p = pending_q.pop_front();
                    req.valid <= 1'b1;
                    req.mode <= p.word.mode;
                    req.frame <= p.word.frame;
                    req.owner <= p.word.owner;
                    req.kind <= p.word.kind;
                    req.phys_address <= p.word.phys_address;
                end
            end
        end
    end

    // Monitor: takes response words and compares them with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        int   stall_pct;

        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("response word with no request outstanding");
                    errors++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    check_field("result_frame", want.result_frame, rsp.result_frame);
                    check_field("evicted", want.evicted, rsp.evicted);
                    check_field("victim_owner", want.victim_owner, rsp.victim_owner);
                    check_field("victim_writeback", want.victim_writeback,
                                rsp.victim_writeback);
                    check_field("freed_count", want.freed_count, rsp.freed_count);
                    check_field("writeback_count", want.writeback_count,
                                rsp.writeback_count);
                    check_field("status", want.status, rsp.status);
                end
            end
            stall_pct = (idle_phase() == 0) ? 71 : (idle_phase() == 1) ? 15 : 0;
            rsp.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] addr;
        int                roll;
        int                first_random;
        bit                fill_heavy;

        errors = 0;
        words_accepted = 0;
        evictions = 0;
        releases = 0;
        frames_freed = 0;
        writebacks = 0;
        bad_marks = 0;
        fill_heavy = 1'b1;

        // A touch of a free frame, then marks on a free frame, on the last frame
        // and beyond the table.
        add_word(MODE_TOUCH, 6'd5, 8'd0, 1'b0, 32'h0, 1'b0);
        add_word(MODE_MARK, 6'd0, 8'd0, 1'b0, 32'h0000_0000, 1'b0);
        add_word(MODE_MARK, 6'd63, 8'hff, 1'b1, 32'hffff_ffff, 1'b0);
        add_word(MODE_MARK, 6'd0, 8'd0, 1'b0, 32'h0001_0000, 1'b0);
        add_word(MODE_MARK, 6'd0, 8'd0, 1'b0, 32'h0000_ffff, 1'b0);
        // Allocations of both kinds, including the owner code that means none.
        add_word(MODE_ALLOC, 6'd0, 8'd0, 1'b0, 32'h0, 1'b0);
        add_word(MODE_ALLOC, 6'd0, 8'd254, 1'b1, 32'h0, 1'b0);
        add_word(MODE_ALLOC, 6'd0, 8'd255, 1'b1, 32'h0, 1'b0);
        add_word(MODE_ALLOC, 6'd0, 8'd254, 1'b0, 32'h0, 1'b0);
        add_word(MODE_TOUCH, 6'd63, 8'd0, 1'b0, 32'h0, 1'b0);
        add_word(MODE_TOUCH, 6'd0, 8'd0, 1'b0, 32'h0, 1'b0);
        add_word(MODE_TOUCH, 6'd2, 8'd0, 1'b0, 32'h0, 1'b0);
        add_word(MODE_MARK, 6'd0, 8'd0, 1'b0, 32'h0000_0400, 1'b0);
        add_word(MODE_MARK, 6'd0, 8'd0, 1'b0, 32'h0000_0fff, 1'b0);
        add_word(MODE_RELEASE, 6'd0, 8'd255, 1'b0, 32'h0, 1'b0);
        add_word(MODE_RELEASE, 6'd0, 8'd7, 1'b0, 32'h0, 1'b0);
        add_word(MODE_RELEASE, 6'd0, 8'd254, 1'b0, 32'h0, 1'b0);
        add_word(MODE_ALLOC, 6'd0, 8'd3, 1'b1, 32'h0, 1'b0);
        add_word(MODE_ALLOC, 6'd0, 8'd3, 1'b0, 32'h0, 1'b0);
        add_word(MODE_RELEASE, 6'd0, 8'd0, 1'b0, 32'h0, 1'b0);

        first_random = pending_q.size();
        words_total = first_random + RANDOM_WORDS;
        phase_len = words_total / 3;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // Fill-heavy blocks exhaust the free queue so that allocation must evict.
            if (n % 100 == 0)
                fill_heavy = (n < 200) || ($urandom_range(1) == 0);
            roll = $urandom_range(99);
            if (fill_heavy)
                mode = (roll < 50) ? MODE_ALLOC : (roll < 80) ? MODE_TOUCH :
                       (roll < 98) ? MODE_MARK : MODE_RELEASE;
            else
                mode = (roll < 30) ? MODE_ALLOC : (roll < 60) ? MODE_TOUCH :
                       (roll < 80) ? MODE_MARK : MODE_RELEASE;
            addr = $urandom();
            if (mode == MODE_MARK && $urandom_range(9) != 0)
                addr[ADDR_W-1:FRAME_SHIFT] = PAGE_W'($urandom_range(FRAMES - 1));
            add_word(mode, FRAME_W'($urandom_range(FRAMES - 1)),
                     ($urandom_range(99) < 85) ? OWNER_W'($urandom_range(7))
                                               : OWNER_W'($urandom_range(255)),
                     1'($urandom_range(1)), addr,
                     n == 0 || first_random + n == phase_len
                     || first_random + n == 2 * phase_len || $urandom_range(199) == 0);
        end

        wait (rst_n === 1'b1);
        while (words_accepted < words_total || answer_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);

        $display("%0d words: %0d evictions, %0d out-of-range marks", words_total,
                 evictions, bad_marks);
        $display("%0d releases freed %0d frames with %0d write-backs", releases,
                 frames_freed, writebacks);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
